[src/wpf_pkg.sv]
package wpf_pkg;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } wpf_op_e;

  // Configuration register indexes.
  localparam logic REG_SPEED  = 1'b0;
  localparam logic REG_RADIUS = 1'b1;

  // Reset values of the configuration registers (100.0 and 1.0 in Q8.16).
  localparam logic [23:0] SPEED_RST  = 24'd6553600;
  localparam logic [23:0] RADIUS_RST = 24'd65536;

  // Datapath widths.
  localparam int unsigned CoordW = 32;
  localparam int unsigned AbsW   = 33;  // magnitude of a coordinate difference
  localparam int unsigned SqW    = 64;  // sum of squares
  localparam int unsigned RootW  = 32;
  localparam int unsigned DistW  = 34;  // root shifted back by the prescale
  localparam int unsigned StepW  = 24;
  localparam int unsigned QuoW   = 57;  // magnitude times step

  // Add a signed move of magnitude mag to pos and saturate to 32 bits.
  function automatic logic signed [CoordW-1:0] sat_add(
      input logic signed [CoordW-1:0] pos,
      input logic                     neg,
      input logic [QuoW-1:0]          mag);
    logic signed [QuoW+1:0] ext_pos;
    logic signed [QuoW+1:0] ext_mag;
    logic signed [QuoW+1:0] sum;
    ext_pos = (QuoW+2)'(pos);
    ext_mag = $signed({2'b00, mag});
    sum = neg ? ext_pos - ext_mag : ext_pos + ext_mag;
    if (sum > (QuoW+2)'(64'sd2147483647)) begin
      return 32'sh7fffffff;
    end else if (sum < (QuoW+2)'(-64'sd2147483648)) begin
      return 32'sh80000000;
    end
    return sum[CoordW-1:0];
  endfunction

endpackage

[src/wpf_store.sv]
module wpf_store import wpf_pkg::*; #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);

  logic [63:0] mem_q [Depth];

  // Waypoint memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/wpf_sqrt.sv]
module wpf_sqrt import wpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SqW-1:0]   radicand_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic             busy_q;
  logic [4:0]       cnt_q;
  logic [SqW-1:0]   rad_q;
  logic [RootW+1:0] rem_q;
  logic [RootW+3:0] trial;
  logic [RootW+3:0] sub;
  logic             ge;

  // One result bit per cycle: bring down two radicand bits and try 4q+1.
  assign trial = {rem_q, rad_q[SqW-1 -: 2]};
  assign sub   = {2'b00, root_o, 2'b01};
  assign ge    = trial >= sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
          rad_q  <= radicand_i;
          rem_q  <= '0;
          root_o <= '0;
        end
      end else begin
        rad_q  <= {rad_q[SqW-3:0], 2'b00};
        rem_q  <= ge ? (RootW+2)'(trial - sub) : (RootW+2)'(trial);
        root_o <= {root_o[RootW-2:0], ge};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // A finished root never coincides with a running iteration.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q)
    else $error("sqrt done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q && cnt_q == 5'(RootW - 1) |=> done_o)
    else $error("sqrt did not finish after the last bit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      start_i && !busy_q |=> busy_q && cnt_q == 5'd0)
    else $error("sqrt start not taken");

endmodule

[src/wpf_div.sv]
module wpf_div import wpf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QuoW-1:0]  dividend_i,
  input  logic [DistW-1:0] divisor_i,
  output logic             done_o,
  output logic [QuoW-1:0]  quot_o
);

  logic             busy_q;
  logic [5:0]       cnt_q;
  logic [DistW-1:0] div_q;
  logic [DistW-1:0] rem_q;
  logic [DistW:0]   trial;
  logic             ge;

  // Restoring division, one quotient bit per cycle; the dividend shifts
  // out of the top of the quotient register as the quotient shifts in.
  assign trial = {rem_q, quot_o[QuoW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          cnt_q  <= '0;
          div_q  <= divisor_i;
          rem_q  <= '0;
          quot_o <= dividend_i;
        end
      end else begin
        rem_q  <= ge ? DistW'(trial - {1'b0, div_q}) : DistW'(trial);
        quot_o <= {quot_o[QuoW-2:0], ge};
        cnt_q  <= cnt_q + 6'd1;
        if (cnt_q == 6'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q)
    else $error("divide done while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q && cnt_q == 6'(QuoW - 1) |=> done_o)
    else $error("divide did not finish after the last bit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      start_i && !busy_q |=> busy_q && cnt_q == 6'd0)
    else $error("divide start not taken");

endmodule

[src/waypoint_path_follower.sv]
// Waypoint path follower. An item is taken when start_i is high and busy_o
// is low; its single result appears on the output ports for exactly one
// cycle with done_o high, and the receiver cannot stall it. Clear, append,
// no-operation and a tick on an empty path put their result on the ports in
// the cycle right after the accepting edge. A tick that reaches or sits on
// its target holds busy_o through the load, difference, square, step, root
// and compare states, and its result follows at once. A tick that moves the
// position holds busy_o on through a shared 33x31 multiplier, which forms
// the squares and products, a bit-serial square root, and one restoring
// divider run for each of the two axes. Configuration writes through
// cfg_we_i take effect at once and should be made while busy_o is low.
module waypoint_path_follower import wpf_pkg::*; #(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [23:0]              cfg_data_i,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               opcode_i,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic [15:0]              time_step_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] new_x_o,
  output logic signed [CoordW-1:0] new_y_o,
  output logic                     following_o,
  output logic [5:0]               target_index_o,
  output logic                     path_finished_o,
  output logic                     append_overflow_o
);

  localparam int unsigned IdxW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CntW = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_DIFF, S_SQX, S_SQY, S_SQS, S_STEP,
    S_SQRT, S_CMP, S_MX, S_DX, S_DXW, S_DYW
  } state_e;

  state_e                   state_q;
  logic [23:0]              speed_q, radius_q;
  logic [CntW-1:0]          cnt_q, cur_q, cur_inc;
  logic signed [CoordW-1:0] px_q, py_q;
  logic [15:0]              dt_q;
  logic [AbsW-1:0]          ax_q, ay_q;
  logic                     negx_q, negy_q, pre_q;
  logic [SqW-1:0]           acc_q;
  logic [StepW-1:0]         step_q;
  logic [DistW-1:0]         dist_q;
  logic [QuoW-1:0]          mvx_q;
  logic [AbsW-1:0]          mul_a_q;
  logic [30:0]              mul_b_q;
  logic [SqW-1:0]           mul_p_q;

  logic                     accept, store_we, full;
  logic [63:0]              rdata;
  logic signed [CoordW:0]   dx, dy;
  logic [AbsW-1:0]          ax, ay;
  logic                     pre;
  logic [30:0]              sxv, syv;
  logic                     sqrt_start, sqrt_done, div_start, div_done;
  logic [RootW-1:0]         root;
  logic [QuoW-1:0]          quot;

  assign busy_o  = state_q != S_IDLE;
  assign accept  = start_i && !busy_o;
  assign full    = cnt_q >= CntW'(MAX_WAYPOINTS);
  assign store_we = accept && opcode_i == OP_APPEND && !full;
  assign cur_inc = cur_q + CntW'(1);

  wpf_store #(.Depth(MAX_WAYPOINTS), .AddrW(IdxW)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i ({coord_x_i, coord_y_i}),
    .raddr_i (cur_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  // Differences to the target, magnitudes and prescale for the square root.
  always_comb begin
    dx  = $signed({rdata[63], rdata[63:32]}) - $signed({px_q[CoordW-1], px_q});
    dy  = $signed({rdata[31], rdata[31:0]}) - $signed({py_q[CoordW-1], py_q});
    ax  = dx[CoordW] ? AbsW'(-dx) : AbsW'(dx);
    ay  = dy[CoordW] ? AbsW'(-dy) : AbsW'(dy);
    pre = ax[AbsW-1] || ax[AbsW-2] || ay[AbsW-1] || ay[AbsW-2];
    sxv = pre ? ax[AbsW-1:2] : ax[30:0];
    syv = pre ? ay[AbsW-1:2] : ay[30:0];
  end

  // Shared multiplier, operands and product both registered.
  always_ff @(posedge clk_i) begin
    mul_p_q <= {31'b0, mul_a_q} * {33'b0, mul_b_q};
  end

  assign sqrt_start = state_q == S_SQS;
  assign div_start  = state_q == S_DX || (state_q == S_DXW && div_done);

  wpf_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (acc_q + mul_p_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  wpf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p_q[QuoW-1:0]),
    .divisor_i  (dist_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Sequencer, path state, configuration and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      speed_q           <= SPEED_RST;
      radius_q          <= RADIUS_RST;
      cnt_q             <= '0;
      cur_q             <= '0;
      done_o            <= 1'b0;
      path_finished_o   <= 1'b0;
      append_overflow_o <= 1'b0;
      following_o       <= 1'b0;
      target_index_o    <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPEED:  speed_q  <= cfg_data_i;
          REG_RADIUS: radius_q <= cfg_data_i;
          default:    speed_q  <= speed_q;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            px_q <= coord_x_i;
            py_q <= coord_y_i;
            dt_q <= time_step_i;
            if (opcode_i == OP_TICK && cur_q < cnt_q) begin
              state_q <= S_LOAD;
            end else begin
              done_o            <= 1'b1;
              new_x_o           <= coord_x_i;
              new_y_o           <= coord_y_i;
              path_finished_o   <= 1'b0;
              append_overflow_o <= opcode_i == OP_APPEND && full;
              following_o       <= cur_q < cnt_q;
              target_index_o    <= 6'(cur_q);
              if (opcode_i == OP_CLEAR) begin
                cnt_q          <= '0;
                cur_q          <= '0;
                following_o    <= 1'b0;
                target_index_o <= '0;
              end else if (store_we) begin
                cnt_q       <= cnt_q + CntW'(1);
                following_o <= cur_q < cnt_q + CntW'(1);
              end
            end
          end
        end
        S_LOAD: state_q <= S_DIFF;
        S_DIFF: begin
          ax_q    <= ax;
          ay_q    <= ay;
          negx_q  <= dx[CoordW];
          negy_q  <= dy[CoordW];
          pre_q   <= pre;
          mul_a_q <= AbsW'(sxv);
          mul_b_q <= sxv;
          state_q <= S_SQX;
        end
        S_SQX: begin
          mul_a_q <= AbsW'(syv);
          mul_b_q <= syv;
          state_q <= S_SQY;
        end
        S_SQY: begin
          acc_q   <= mul_p_q;
          mul_a_q <= AbsW'(speed_q);
          mul_b_q <= 31'(dt_q);
          state_q <= S_SQS;
        end
        S_SQS: state_q <= S_STEP;
        S_STEP: begin
          step_q  <= mul_p_q[16 +: StepW];
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            dist_q  <= pre_q ? {root, 2'b00} : {2'b00, root};
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (dist_q < DistW'(radius_q) || dist_q == '0) begin
            state_q         <= S_IDLE;
            done_o          <= 1'b1;
            new_x_o         <= px_q;
            new_y_o         <= py_q;
            path_finished_o <= 1'b0;
            append_overflow_o <= 1'b0;
            following_o     <= 1'b1;
            target_index_o  <= 6'(cur_q);
            if (dist_q < DistW'(radius_q)) begin
              if (cur_inc >= cnt_q) begin
                cur_q           <= '0;
                cnt_q           <= '0;
                path_finished_o <= 1'b1;
                following_o     <= 1'b0;
                target_index_o  <= '0;
              end else begin
                cur_q          <= cur_inc;
                target_index_o <= 6'(cur_inc);
              end
            end
          end else begin
            mul_a_q <= ax_q;
            mul_b_q <= 31'(step_q);
            state_q <= S_MX;
          end
        end
        S_MX: state_q <= S_DX;
        S_DX: begin
          mul_a_q <= ay_q;
          state_q <= S_DXW;
        end
        S_DXW: begin
          if (div_done) begin
            mvx_q   <= quot;
            state_q <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_done) begin
            state_q           <= S_IDLE;
            done_o            <= 1'b1;
            new_x_o           <= sat_add(px_q, negx_q, mvx_q);
            new_y_o           <= sat_add(py_q, negy_q, quot);
            path_finished_o   <= 1'b0;
            append_overflow_o <= 1'b0;
            following_o       <= 1'b1;
            target_index_o    <= 6'(cur_q);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // The target index stays inside the path, and both reset together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cur_q < cnt_q || (cur_q == '0 && cnt_q == '0))
    else $error("target index outside path");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= CntW'(MAX_WAYPOINTS))
    else $error("waypoint count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      accept && opcode_i != OP_TICK |=> done_o && !busy_o)
    else $error("non-tick transaction did not finish at once");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      done_o && path_finished_o |-> !following_o && target_index_o == '0)
    else $error("finished path still followed");

endmodule

[tb/sv/testbench.sv]
module testbench import wpf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumWaypoints = 64;
  localparam int unsigned RandomItems  = 700;
  localparam int unsigned CycleLimit   = 600000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = REG_SPEED;
  logic [23:0]       cfg_data_i = '0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [1:0]        opcode_i = OP_NOP;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic [15:0]       time_step_i = '0;
  logic              done_o;
  logic signed [31:0] new_x_o;
  logic signed [31:0] new_y_o;
  logic              following_o;
  logic [5:0]        target_index_o;
  logic              path_finished_o;
  logic              append_overflow_o;

  waypoint_path_follower u_top (.*);

  always #5 clk_i = ~clk_i;

  // One result of the block, as predicted.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               following;
    logic [5:0]         index;
    logic               finished;
    logic               overflow;
  } motion_t;

  // Predictor state.
  logic signed [31:0] path_x [NumWaypoints];
  logic signed [31:0] path_y [NumWaypoints];
  int unsigned path_len;
  int unsigned path_pos;
  logic [23:0] cur_speed;
  logic [23:0] cur_radius;

  motion_t pending_motion[$];
  int unsigned error_count = 0;
  int unsigned motion_count = 0;
  int unsigned move_count = 0;
  int unsigned finish_count = 0;
  longint unsigned cycle_count = 0;
  bit pace_sender = 1'b1;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clamp32(longint signed v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Work out the result of one transaction and update the predictor state.
  function automatic motion_t predict_motion(logic [1:0] op, logic signed [31:0] px,
                                             logic signed [31:0] py, logic [15:0] dt);
    motion_t r;
    longint signed dx, dy;
    longint unsigned ax, ay, mx, sq, dist_u, stp, mvx, mvy;
    int unsigned sh;
    r = '0;
    r.x = px;
    r.y = py;
    case (op)
      OP_CLEAR: begin
        path_len = 0;
        path_pos = 0;
      end
      OP_APPEND: begin
        if (path_len < NumWaypoints) begin
          path_x[path_len] = px;
          path_y[path_len] = py;
          path_len++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      OP_TICK: begin
        if (path_pos < path_len) begin
          dx = longint'(path_x[path_pos]) - longint'(px);
          dy = longint'(path_y[path_pos]) - longint'(py);
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          mx = ax > ay ? ax : ay;
          sh = (mx >= 64'd2147483648) ? 2 : 0;
          sq = (ax >> sh) * (ax >> sh) + (ay >> sh) * (ay >> sh);
          dist_u = int_sqrt(sq) << sh;
          if (dist_u < cur_radius) begin
            path_pos++;
            if (path_pos >= path_len) begin
              path_len = 0;
              path_pos = 0;
              r.finished = 1'b1;
            end
          end else if (dist_u != 0) begin
            stp = (longint'(cur_speed) * dt) >> 16;
            mvx = (ax * stp) / dist_u;
            mvy = (ay * stp) / dist_u;
            r.x = clamp32(longint'(px) + (dx < 0 ? -longint'(mvx) : longint'(mvx)));
            r.y = clamp32(longint'(py) + (dy < 0 ? -longint'(mvy) : longint'(mvy)));
            move_count++;
          end
        end
      end
      default: ;
    endcase
    r.following = path_pos < path_len;
    r.index = path_pos[5:0];
    return r;
  endfunction

  // Check every result against the oldest prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      motion_t got, want;
      got = '{new_x_o, new_y_o, following_o, target_index_o, path_finished_o,
              append_overflow_o};
      if (pending_motion.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        error_count++;
      end else begin
        want = pending_motion.pop_front();
        motion_count++;
        if (got.finished) finish_count++;
        if (got.x !== want.x) begin
          $display("%0t: new_x expected %h actual %h", $realtime, want.x, got.x);
          error_count++;
        end
        if (got.y !== want.y) begin
          $display("%0t: new_y expected %h actual %h", $realtime, want.y, got.y);
          error_count++;
        end
        if (got.following !== want.following) begin
          $display("%0t: following expected %b actual %b", $realtime, want.following,
                   got.following);
          error_count++;
        end
        if (got.index !== want.index) begin
          $display("%0t: target_index expected %0d actual %0d", $realtime, want.index,
                   got.index);
          error_count++;
        end
        if (got.finished !== want.finished) begin
          $display("%0t: path_finished expected %b actual %b", $realtime,
                   want.finished, got.finished);
          error_count++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: append_overflow expected %b actual %b", $realtime,
                   want.overflow, got.overflow);
          error_count++;
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               pending_motion.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Send one transaction, with a random gap before it while pacing is on.
  // Start stays high after the accepting edge so that items can follow
  // back to back; every idle wait drops it first.
  task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                           logic [15:0] dt);
    int unsigned gap;
    motion_t guess;
    if (pace_sender && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    coord_x_i <= x;
    coord_y_i <= y;
    time_step_i <= dt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    guess = predict_motion(op, x, y, dt);
    pending_motion = {pending_motion, guess};
  endtask

  // Let the block drain, then write one register.
  task automatic write_reg(logic idx, logic [23:0] val);
    start_i <= 1'b0;
    while (pending_motion.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SPEED) cur_speed = val;
    else cur_radius = val;
  endtask

  function automatic logic signed [31:0] rand_coord(int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
      default: return $signed($urandom_range(0, 32'h08000000)) - 32'sh04000000;
    endcase
  endfunction

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        dt;
    bit                 fixed;
    motion_t            want;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{OP_TICK, 32'sh00010000, 32'sh00020000, 16'hffff, 1'b1,
      '{32'sh00010000, 32'sh00020000, 1'b0, 6'd0, 1'b0, 1'b0}},
    '{OP_NOP, 32'sh7fffffff, 32'sh80000000, 16'h0000, 1'b1,
      '{32'sh7fffffff, 32'sh80000000, 1'b0, 6'd0, 1'b0, 1'b0}},
    '{OP_APPEND, 32'sh7fffffff, 32'sh7fffffff, 16'h0, 1'b1,
      '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 6'd0, 1'b0, 1'b0}},
    '{OP_APPEND, 32'sh80000000, 32'sh80000000, 16'h0, 1'b0, '0},
    '{OP_APPEND, 32'sh00000000, 32'sh00000000, 16'h0, 1'b0, '0},
    '{OP_TICK, 32'sh80000000, 32'sh80000000, 16'hffff, 1'b0, '0},
    '{OP_TICK, 32'sh7fff8000, 32'sh7fff8000, 16'h1000, 1'b0, '0},
    '{OP_TICK, 32'sh7fffffff, 32'sh7fffffff, 16'h1000, 1'b0, '0},
    '{OP_TICK, 32'sh7fffffff, 32'sh7fffffff, 16'h0000, 1'b0, '0},
    '{OP_TICK, 32'sh00100000, 32'shfff00000, 16'h4000, 1'b0, '0},
    '{OP_TICK, 32'sh00008000, 32'sh00000000, 16'h4000, 1'b0, '0},
    '{OP_TICK, 32'sh00000000, 32'sh00000000, 16'h4000, 1'b0, '0},
    '{OP_CLEAR, 32'sh12345678, 32'shedcba987, 16'hffff, 1'b1,
      '{32'sh12345678, 32'shedcba987, 1'b0, 6'd0, 1'b0, 1'b0}},
    '{OP_NOP, 32'sh0, 32'sh0, 16'h0, 1'b1, '{32'sh0, 32'sh0, 1'b0, 6'd0, 1'b0, 1'b0}}
  };

  initial begin
    int unsigned n, mode, len;
    logic signed [31:0] px, py;
    motion_t want;
    path_len = 0;
    path_pos = 0;
    cur_speed = SPEED_RST;
    cur_radius = RADIUS_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; fixed rows carry their expected result.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].dt);
      if (directed_rows[i].fixed) begin
        want = pending_motion[pending_motion.size() - 1];
        if (want !== directed_rows[i].want) begin
          $display("%0t: directed row %0d expected %h actual %h", $realtime, i,
                   directed_rows[i].want, want);
          error_count++;
        end
      end
    end

    // Fill the store to overflow, then wait for the block to drain.
    for (int i = 0; i < NumWaypoints + 2; i++) begin
      send_item(OP_APPEND, $urandom(), $urandom(), 16'($urandom()));
    end
    start_i <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk_i);
    send_item(OP_CLEAR, 0, 0, 16'd0);

    // Radius zero: a tick sitting on its target never arrives.
    write_reg(REG_RADIUS, 24'd0);
    write_reg(REG_SPEED, 24'hffffff);
    send_item(OP_APPEND, 32'sh00050000, 32'sh00050000, 16'd0);
    send_item(OP_TICK, 32'sh00050000, 32'sh00050000, 16'hffff);
    send_item(OP_TICK, 32'sh80000000, 32'sh7fffffff, 16'hffff);
    send_item(OP_CLEAR, 0, 0, 16'd0);

    // Random paths over several register settings.
    n = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(REG_SPEED, SPEED_RST); write_reg(REG_RADIUS, 24'hffffff); end
        1: begin write_reg(REG_SPEED, 24'd0); write_reg(REG_RADIUS, 24'h080000); end
        2: begin
          write_reg(REG_SPEED, 24'($urandom()));
          write_reg(REG_RADIUS, 24'($urandom()));
        end
        default: begin
          write_reg(REG_SPEED, 24'h640000); write_reg(REG_RADIUS, 24'h100000);
          pace_sender = 1'b0;
        end
      endcase
      while (n < (phase + 1) * RandomItems / 4) begin
        mode = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) begin
          send_item(2'($urandom_range(0, 3)), $urandom(), $urandom(), 16'($urandom()));
          n++;
        end else begin
          send_item(OP_CLEAR, $urandom(), $urandom(), 16'($urandom()));
          len = $urandom_range(1, 5);
          for (int k = 0; k < len; k++) begin
            send_item(OP_APPEND, rand_coord(mode), rand_coord(mode), 16'($urandom()));
          end
          px = rand_coord(mode);
          py = rand_coord(mode);
          for (int k = 0; k < 8 && path_len != 0; k++) begin
            // Aim near the current target one time in three so ticks can arrive.
            if ($urandom_range(0, 2) == 0) begin
              px = path_x[path_pos] + $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
              py = path_y[path_pos] + $signed($urandom_range(0, 32'h30000)) - 32'sh18000;
            end
            send_item(OP_TICK, px, py, 16'($urandom()));
            px = pending_motion[pending_motion.size() - 1].x;
            py = pending_motion[pending_motion.size() - 1].y;
          end
          n += len + 9;
        end
      end
      if (phase == 1) begin
        // Hold off until every outstanding result has arrived.
        start_i <= 1'b0;
        while (pending_motion.size() != 0) @(posedge clk_i);
      end
    end

    start_i <= 1'b0;
    while (pending_motion.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d results, %0d moving ticks, %0d finished paths,", motion_count,
             move_count, finish_count);
    $display("with overflow, zero radius, saturation and four register settings.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
